// ===== hdl/pite_pkg.sv =====
`default_nettype none

package pite_pkg;

   // Depth of the queue between the front and the back part.
   localparam int unsigned QUEUE_DEPTH = 4;

   // Hash constants.
   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
   localparam logic [31:0] MULT_INIT = 32'd5381;
   localparam logic [31:0] SDBM_INIT = 32'd0;

   // Byte counter saturates here.
   localparam logic [3:0] SEEN_MAX = 4'd9;

   // Tag mode register codes; the unused code behaves as no tag.
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_CRC  = 2'd1;
   localparam logic [1:0] MODE_DUAL = 2'd2;

   // Command codes.
   localparam logic CMD_GENERATE = 1'b0;
   localparam logic CMD_VERIFY   = 1'b1;

   // Tag lengths in bytes.
   localparam logic [3:0] TAG_LEN_NONE = 4'd0;
   localparam logic [3:0] TAG_LEN_CRC  = 4'd4;
   localparam logic [3:0] TAG_LEN_DUAL = 4'd8;

   // Register file: one word-aligned register, selected by the word index bit.
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam logic        CSR_TAG_MODE = 1'b0;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_TAG     = 2'd1,
      KIND_STATUS  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_SHORT    = 2'd1,
      STAT_MISMATCH = 2'd2
   } stat_type;

   // One queued item: the results it causes, in emission order
   // (payload byte, then tag bytes, then status).
   typedef struct packed {
      logic        pay_pend;
      logic [7:0]  pay_byte;
      logic        pay_last;
      logic [3:0]  tag_left;
      logic [63:0] tag_word;
      logic        stat_pend;
      stat_type    stat_val;
   } op_type;

   // Reflected CRC-32 update over one byte.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

   // Tag length of a mode.
   function automatic logic [3:0] tag_len(input logic [1:0] mode);
      logic [3:0] len;
      case (mode)
         MODE_CRC:  len = TAG_LEN_CRC;
         MODE_DUAL: len = TAG_LEN_DUAL;
         default:   len = TAG_LEN_NONE;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/pite_front.sv =====
`default_nettype none

module pite_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [1:0]         tag_mode,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_cmd,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_is_last,
   input  wire logic               queue_full,
   output logic                    push,
   output pite_pkg::op_type        push_op
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] mult_ff, mult_in;
   logic [31:0] sdbm_ff, sdbm_in;
   logic [3:0]  seen_ff, seen_in;
   logic [7:0]  window_ff [8];
   logic [7:0]  window_in [8];

   logic        accept;
   logic [3:0]  tlen;
   logic        verify;
   logic        has_tag;
   logic        drain;
   logic [2:0]  leave_idx;
   logic [7:0]  leaving;
   logic        absorb;
   logic [7:0]  absorb_byte;
   logic [31:0] crc_new, mult_new, sdbm_new;
   logic [63:0] tag_word;
   logic [63:0] win_flat;
   logic        match;
   logic        too_short;
   pite_pkg::stat_type stat_val;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;

   // Classify the item against the current mode and byte count.
   assign tlen      = pite_pkg::tag_len(tag_mode);
   assign verify    = (req_cmd == pite_pkg::CMD_VERIFY);
   assign has_tag   = (tlen != pite_pkg::TAG_LEN_NONE);
   assign drain     = (seen_ff >= tlen);
   assign leave_idx = 3'(4'd8 - tlen);
   assign leaving   = window_ff[leave_idx];

   // In verify mode with a tag, the byte leaving the window is the one hashed.
   assign absorb      = !verify || !has_tag || drain;
   assign absorb_byte = (verify && has_tag) ? leaving : req_data_byte;

   // Hash updates for this item.
   always_comb begin
      crc_new  = crc_ff;
      mult_new = mult_ff;
      sdbm_new = sdbm_ff;
      if (absorb) begin
         crc_new  = pite_pkg::crc_byte(crc_ff, absorb_byte);
         mult_new = ((mult_ff << 5) + mult_ff) ^ {24'd0, absorb_byte};
         sdbm_new = {24'd0, absorb_byte} + (sdbm_ff << 6) + (sdbm_ff << 16) - sdbm_ff;
      end
   end

   // Tag bytes, most significant first.
   assign tag_word = (tlen == pite_pkg::TAG_LEN_CRC) ? {~crc_new, 32'd0}
                                                     : {mult_new, sdbm_new};

   // Window after taking the new byte; the oldest entry sits on top of the flat word.
   always_comb begin
      for (int i = 0; i < 7; i++) begin
         window_in[i] = window_ff[i + 1];
      end
      window_in[7] = req_data_byte;
      for (int i = 0; i < 8; i++) begin
         win_flat[63 - 8 * i -: 8] = window_in[i];
      end
   end

   // Final status of a verified packet.
   assign match     = (tlen == pite_pkg::TAG_LEN_CRC) ? (win_flat[31:0] == tag_word[63:32])
                                                      : (win_flat == tag_word);
   assign too_short = (({1'b0, seen_ff} + 5'd1) < {1'b0, tlen});

   always_comb begin
      if (!has_tag) begin
         stat_val = pite_pkg::STAT_OK;
      end else if (too_short) begin
         stat_val = pite_pkg::STAT_SHORT;
      end else if (!match) begin
         stat_val = pite_pkg::STAT_MISMATCH;
      end else begin
         stat_val = pite_pkg::STAT_OK;
      end
   end

   // Build the queue entry.
   always_comb begin
      push_op.tag_word = tag_word;
      push_op.stat_val = stat_val;
      if (!verify) begin
         push_op.pay_pend  = 1'b1;
         push_op.pay_byte  = req_data_byte;
         push_op.pay_last  = req_is_last && !has_tag;
         push_op.tag_left  = req_is_last ? tlen : 4'd0;
         push_op.stat_pend = 1'b0;
      end else begin
         push_op.pay_pend  = !has_tag || drain;
         push_op.pay_byte  = has_tag ? leaving : req_data_byte;
         push_op.pay_last  = 1'b0;
         push_op.tag_left  = 4'd0;
         push_op.stat_pend = req_is_last;
      end
   end

   // Items that cause no result are not queued.
   assign push = accept && (push_op.pay_pend || push_op.stat_pend || (push_op.tag_left != 4'd0));

   // Next packet state; the last byte returns the hashes and the count to reset values.
   always_comb begin
      crc_in  = crc_ff;
      mult_in = mult_ff;
      sdbm_in = sdbm_ff;
      seen_in = seen_ff;
      if (accept) begin
         if (req_is_last) begin
            crc_in  = pite_pkg::CRC_INIT;
            mult_in = pite_pkg::MULT_INIT;
            sdbm_in = pite_pkg::SDBM_INIT;
            seen_in = 4'd0;
         end else begin
            crc_in  = crc_new;
            mult_in = mult_new;
            sdbm_in = sdbm_new;
            seen_in = (seen_ff < pite_pkg::SEEN_MAX) ? seen_ff + 4'd1 : seen_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff  <= pite_pkg::CRC_INIT;
         mult_ff <= pite_pkg::MULT_INIT;
         sdbm_ff <= pite_pkg::SDBM_INIT;
         seen_ff <= 4'd0;
      end else begin
         crc_ff  <= crc_in;
         mult_ff <= mult_in;
         sdbm_ff <= sdbm_in;
         seen_ff <= seen_in;
      end
   end

   // The window only moves in verify mode.
   always_ff @(posedge clock) begin
      if (accept && verify) begin
         window_ff <= window_in;
      end
   end

   // A packet end always clears the byte count.
   assert property (@(posedge clock) disable iff (reset)
      accept && req_is_last |=> seen_ff == 4'd0)
      else $error("byte count not cleared after packet end");

   // A generated packet always queues its payload byte.
   assert property (@(posedge clock) disable iff (reset)
      accept && !verify |-> push && push_op.pay_pend)
      else $error("generate item not queued");

endmodule

`default_nettype wire

// ===== hdl/pite_queue.sv =====
`default_nettype none

module pite_queue #(
   parameter int unsigned Depth = pite_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire pite_pkg::op_type  push_op,
   input  wire logic              pop,
   output pite_pkg::op_type       head_op,
   output logic                   empty,
   output logic                   full
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   pite_pkg::op_type store_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign empty   = (count_ff == CntW'(0));
   assign full    = (count_ff == CntW'(Depth));
   assign head_op = store_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? PtrW'(0) : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? PtrW'(0) : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_op;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue overflow");

endmodule

`default_nettype wire

// ===== hdl/pite_back.sv =====
`default_nettype none

module pite_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pite_pkg::op_type  head_op,
   input  wire logic              empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic [1:0]             rsp_out_kind,
   output logic                   rsp_out_last,
   output logic [1:0]             rsp_status
);

   pite_pkg::op_type   op_ff;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         byte_ff;
   pite_pkg::kind_type kind_ff;
   logic               last_ff;
   pite_pkg::stat_type stat_ff;

   pite_pkg::op_type   view;
   pite_pkg::op_type   rest;
   logic               view_valid;
   logic               emit;
   logic [7:0]         res_byte;
   pite_pkg::kind_type res_kind;
   logic               res_last;
   pite_pkg::stat_type res_stat;

   // Work on the held item, or straight from the queue head when none is held.
   assign view       = busy_ff ? op_ff : head_op;
   assign view_valid = busy_ff || !empty;
   assign emit       = view_valid && (!rsp_valid_ff || rsp_ready);
   assign pop        = emit && !busy_ff;

   // Pick the next result of the item and what remains of it.
   always_comb begin
      rest     = view;
      res_byte = 8'd0;
      res_kind = pite_pkg::KIND_STATUS;
      res_last = 1'b1;
      res_stat = pite_pkg::STAT_OK;
      if (view.pay_pend) begin
         res_byte      = view.pay_byte;
         res_kind      = pite_pkg::KIND_PAYLOAD;
         res_last      = view.pay_last;
         rest.pay_pend = 1'b0;
      end else if (view.tag_left != 4'd0) begin
         res_byte      = view.tag_word[63:56];
         res_kind      = pite_pkg::KIND_TAG;
         res_last      = (view.tag_left == 4'd1);
         rest.tag_left = view.tag_left - 4'd1;
         rest.tag_word = {view.tag_word[55:0], 8'd0};
      end else begin
         res_stat       = view.stat_val;
         rest.stat_pend = 1'b0;
      end
   end

   assign busy_in      = emit ? (rest.pay_pend || rest.stat_pend || (rest.tag_left != 4'd0))
                              : busy_ff;
   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Held item and output register.
   always_ff @(posedge clock) begin
      if (emit) begin
         op_ff   <= rest;
         byte_ff <= res_byte;
         kind_ff <= res_kind;
         last_ff <= res_last;
         stat_ff <= res_stat;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_out_last = last_ff;
   assign rsp_status   = stat_ff;

   assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == pite_pkg::KIND_STATUS |-> last_ff)
      else $error("status result not marked last");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff != pite_pkg::KIND_STATUS |-> stat_ff == pite_pkg::STAT_OK)
      else $error("nonzero status on a data result");

endmodule

`default_nettype wire

// ===== hdl/packet_integrity_tag_engine.sv =====
// Packet integrity tag engine: byte-serial CRC-32 or dual-hash tag generation and checking.
// Packet bytes enter on the req_ channel (valid/ready), one item per byte, with req_is_last
// on the final byte and req_cmd choosing generate (append tag) or verify (strip and check).
// Results leave on the rsp_ channel (valid/ready): payload bytes, appended tag bytes, and
// in verify mode a final status item. The tag mode register sits at byte address 0 of the
// csr_ port and resets to CRC-32.
// The front part takes one byte per cycle while the queue has room, hashes it, and queues
// its results; the back part sends one result per cycle while the receiver is ready, through
// an output register. The first result of an item passes through the queue, then the output
// register. A generate packet end adds 4 or 8 tag bytes, a verify packet end a status item,
// and the queue depth sets how far the input may run ahead while those results are sent.
// When the receiver stalls, results wait in the output register and the queue, and
// req_ready drops once the queue is full; nothing is lost or reordered.
// Reset clears the hashes, the byte count, the queue and the output register; the
// verify window holds no defined bytes until a packet has filled it.
`default_nettype none

module packet_integrity_tag_engine #(
   parameter int unsigned QueueDepth = pite_pkg::QUEUE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_cmd,
   input  wire logic [7:0]                      req_data_byte,
   input  wire logic                            req_is_last,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [7:0]                           rsp_out_byte,
   output logic [1:0]                           rsp_out_kind,
   output logic                                 rsp_out_last,
   output logic [1:0]                           rsp_status,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [pite_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);

   logic [1:0]       tag_mode_ff, tag_mode_in;
   logic             csr_hit;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_empty;
   pite_pkg::op_type push_op;
   pite_pkg::op_type head_op;

   // Register file.
   assign csr_pready  = 1'b1;
   assign csr_hit     = (csr_paddr[pite_pkg::CSR_ADDR_W-1] == pite_pkg::CSR_TAG_MODE);
   assign tag_mode_in = (csr_psel && csr_penable && csr_pwrite && csr_hit) ? csr_pwdata[1:0]
                                                                           : tag_mode_ff;
   assign csr_prdata  = csr_hit ? {30'd0, tag_mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_mode_ff <= pite_pkg::MODE_CRC;
      end else begin
         tag_mode_ff <= tag_mode_in;
      end
   end

   pite_front u_front (
      .clock         (clock),
      .reset         (reset),
      .tag_mode      (tag_mode_ff),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .req_is_last   (req_is_last),
      .queue_full    (queue_full),
      .push          (push),
      .push_op       (push_op)
   );

   pite_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .empty   (queue_empty),
      .full    (queue_full)
   );

   pite_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_op      (head_op),
      .empty        (queue_empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_last (rsp_out_last),
      .rsp_status   (rsp_status)
   );

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;

   localparam int CLK_PERIOD    = 20;
   localparam int QUIET_LIMIT   = 1000;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS   = 17;
   localparam int RANDOM_PHASES = 7;

   // Tag mode code with no defined meaning; the engine treats it as no tag.
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Byte address of the tag mode register.
   localparam logic [pite_pkg::CSR_ADDR_W-1:0] TAG_MODE_ADDR = {pite_pkg::CSR_TAG_MODE, 2'b00};

   // How a verify packet ends: with its correct tag, with one tag bit flipped,
   // or with no tag appended at all.
   localparam int TAIL_GOOD    = 0;
   localparam int TAIL_FLIPPED = 1;
   localparam int TAIL_RAW     = 2;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
      logic       last;
   } in_byte_type;

   typedef struct packed {
      logic [7:0]         data;
      pite_pkg::kind_type kind;
      logic               last;
      pite_pkg::stat_type status;
   } out_byte_type;

   typedef struct packed {
      logic [31:0] crc;
      logic [31:0] mult;
      logic [31:0] sdbm;
   } hash_type;

   localparam hash_type HASH_START = {pite_pkg::CRC_INIT, pite_pkg::MULT_INIT,
                                      pite_pkg::SDBM_INIT};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = 1'b0;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_is_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_out_kind;
   logic        rsp_out_last;
   logic [1:0]  rsp_status;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [pite_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Bytes waiting to be sent and the output stream the engine should produce.
   in_byte_type  in_bytes_q[$];
   out_byte_type out_stream_q[$];
   out_byte_type next_out;

   // Copy of the engine state used for prediction.
   hash_type   model_hash = HASH_START;
   logic [7:0] model_window [8];
   logic [3:0] model_seen = 4'd0;
   logic [1:0] model_mode = pite_pkg::MODE_CRC;

   int error_count = 0;
   int items_queued = 0;
   int quiet_cycles = 0;
   int burst_left = 1;
   int send_gap = 0;
   int ready_run = 0;
   int stall_run = 0;

   packet_integrity_tag_engine dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cmd       (req_cmd),
      .req_data_byte (req_data_byte),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_last  (rsp_out_last),
      .rsp_status    (rsp_status),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   task automatic flag_error(input string msg);
      error_count++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   // Advance CRC-32, the multiplicative hash and the sdbm hash by one byte.
   function automatic hash_type hash_byte(input hash_type h, input logic [7:0] b);
      hash_type    n;
      logic [31:0] c;
      int          k;
      c = h.crc ^ {24'd0, b};
      for (k = 0; k < 8; k++) c = (c >> 1) ^ (pite_pkg::CRC_POLY & {32{c[0]}});
      n.crc  = c;
      n.mult = (h.mult * 32'd33) ^ {24'd0, b};
      n.sdbm = {24'd0, b} + (h.sdbm << 6) + (h.sdbm << 16) - h.sdbm;
      return n;
   endfunction

   function automatic int tag_len_of(input logic [1:0] mode);
      if (mode == pite_pkg::MODE_CRC) return 4;
      if (mode == pite_pkg::MODE_DUAL) return 8;
      return 0;
   endfunction

   // Byte i of the big-endian tag; the dual tag is the multiplicative hash then sdbm.
   function automatic logic [7:0] tag_byte_of(input hash_type h, input logic [1:0] mode,
                                              input int i);
      logic [31:0] w;
      if (mode == pite_pkg::MODE_CRC) w = ~h.crc;
      else w = (i < 4) ? h.mult : h.sdbm;
      return w[8 * (3 - (i % 4)) +: 8];
   endfunction

   // Byte values lean toward the extremes now and then.
   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Work out the output bytes that one accepted input item causes.
   task automatic run_tag_engine(input in_byte_type it);
      int                 t;
      logic [3:0]         n;
      logic [7:0]         leaving;
      pite_pkg::stat_type st;
      t = tag_len_of(model_mode);
      n = model_seen;
      if (model_seen < pite_pkg::SEEN_MAX) model_seen = model_seen + 4'd1;
      if (it.cmd == pite_pkg::CMD_GENERATE) begin
         model_hash = hash_byte(model_hash, it.data);
         out_stream_q.push_back('{it.data, pite_pkg::KIND_PAYLOAD, (t == 0) ? it.last : 1'b0,
                                  pite_pkg::STAT_OK});
         if (it.last) begin
            for (int i = 0; i < t; i++) begin
               out_stream_q.push_back('{tag_byte_of(model_hash, model_mode, i),
                                        pite_pkg::KIND_TAG, (i + 1 == t), pite_pkg::STAT_OK});
            end
            model_hash = HASH_START;
            model_seen = 4'd0;
         end
      end else begin
         // Verify: payload leaves the window once the tag length is covered.
         if (t == 0) begin
            model_hash = hash_byte(model_hash, it.data);
            out_stream_q.push_back('{it.data, pite_pkg::KIND_PAYLOAD, 1'b0, pite_pkg::STAT_OK});
         end else if (n >= t) begin
            leaving = model_window[8 - t];
            model_hash = hash_byte(model_hash, leaving);
            out_stream_q.push_back('{leaving, pite_pkg::KIND_PAYLOAD, 1'b0, pite_pkg::STAT_OK});
         end
         for (int k = 0; k < 7; k++) model_window[k] = model_window[k + 1];
         model_window[7] = it.data;
         if (it.last) begin
            st = pite_pkg::STAT_OK;
            if (t != 0) begin
               if (n + 1 < t) begin
                  st = pite_pkg::STAT_SHORT;
               end else begin
                  for (int i = 0; i < t; i++) begin
                     if (model_window[8 - t + i] != tag_byte_of(model_hash, model_mode, i))
                        st = pite_pkg::STAT_MISMATCH;
                  end
               end
            end
            out_stream_q.push_back('{8'd0, pite_pkg::KIND_STATUS, 1'b1, st});
            model_hash = HASH_START;
            model_seen = 4'd0;
         end
      end
   endtask

   // Queue one packet: len payload bytes, and for verify the tail the form asks for.
   task automatic queue_packet(input logic cmd, input logic [1:0] mode, input int len,
                               input int tail);
      hash_type   h;
      logic [7:0] b;
      int         t;
      int         total;
      int         flip;
      h = HASH_START;
      t = (cmd == pite_pkg::CMD_VERIFY && tail != TAIL_RAW) ? tag_len_of(mode) : 0;
      if (len + t == 0) len = 1;
      total = len + t;
      flip = (t > 0) ? $urandom_range(0, 8 * t - 1) : 0;
      for (int i = 0; i < total; i++) begin
         if (i < len) begin
            b = rand_byte();
            h = hash_byte(h, b);
         end else begin
            b = tag_byte_of(h, mode, i - len);
            if (tail == TAIL_FLIPPED && i - len == flip / 8) b[flip % 8] = ~b[flip % 8];
         end
         in_bytes_q.push_back('{cmd, b, (i == total - 1)});
      end
      items_queued += total;
   endtask

   // Wait until every byte is sent and every output byte has arrived.
   task automatic wait_idle();
      do @(posedge clock);
      while (in_bytes_q.size() != 0 || req_valid || out_stream_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the tag mode register, then read it back.
   task automatic write_tag_mode(input logic [1:0] mode);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TAG_MODE_ADDR;
      csr_pwdata  <= {30'd0, mode};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      model_mode = mode;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      if (csr_prdata[1:0] !== mode)
         flag_error($sformatf("tag mode read back %0d, wrote %0d", csr_prdata[1:0], mode));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Sender: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) run_tag_engine(in_bytes_q.pop_front());
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (in_bytes_q.size() > 0) begin
               req_valid     <= 1'b1;
               req_cmd       <= in_bytes_q[0].cmd;
               req_data_byte <= in_bytes_q[0].data;
               req_is_last   <= in_bytes_q[0].last;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                           : $urandom_range(1, 10);
                  send_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each output byte, and stall in runs of its own.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_run = 0;
         stall_run = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (out_stream_q.size() == 0) begin
               flag_error($sformatf("unexpected output byte %02h kind %0d",
                                    rsp_out_byte, rsp_out_kind));
            end else begin
               next_out = out_stream_q.pop_front();
               if (rsp_out_byte !== next_out.data || rsp_out_kind !== next_out.kind ||
                   rsp_out_last !== next_out.last || rsp_status !== next_out.status)
                  flag_error($sformatf({"output got byte %02h kind %0d last %0b status %0d,",
                                        " want byte %02h kind %0d last %0b status %0d"},
                                       rsp_out_byte, rsp_out_kind, rsp_out_last, rsp_status,
                                       next_out.data, next_out.kind, next_out.last,
                                       next_out.status));
            end
         end
         if (ready_run > 0) begin
            ready_run--;
            rsp_ready <= 1'b1;
         end else if (stall_run > 0) begin
            stall_run--;
            rsp_ready <= 1'b0;
         end else begin
            ready_run = $urandom_range(1, 24);
            stall_run = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      logic [1:0] mode_plan [5];
      logic [1:0] mode;
      int         start;
      int         sel;
      int         len;
      mode_plan = '{pite_pkg::MODE_DUAL, pite_pkg::MODE_NONE, MODE_UNUSED, pite_pkg::MODE_CRC,
                    pite_pkg::MODE_DUAL};

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // CRC mode out of reset. The first verify packet fills the whole window.
      queue_packet(pite_pkg::CMD_VERIFY, pite_pkg::MODE_CRC, 8, TAIL_RAW);
      in_bytes_q.push_back('{pite_pkg::CMD_GENERATE, 8'h00, 1'b0});
      in_bytes_q.push_back('{pite_pkg::CMD_GENERATE, 8'hFF, 1'b1});
      queue_packet(pite_pkg::CMD_VERIFY, pite_pkg::MODE_CRC, 1, TAIL_RAW);
      queue_packet(pite_pkg::CMD_VERIFY, pite_pkg::MODE_CRC, 1, TAIL_GOOD);
      wait_idle();

      // No tag: plain pass-through with an ok status on verify.
      write_tag_mode(pite_pkg::MODE_NONE);
      queue_packet(pite_pkg::CMD_VERIFY, pite_pkg::MODE_NONE, 1, TAIL_GOOD);
      queue_packet(pite_pkg::CMD_GENERATE, pite_pkg::MODE_NONE, 1, TAIL_GOOD);
      wait_idle();

      // Dual hash over an empty payload.
      write_tag_mode(pite_pkg::MODE_DUAL);
      queue_packet(pite_pkg::CMD_VERIFY, pite_pkg::MODE_DUAL, 0, TAIL_GOOD);

      // Random phases, each under one tag mode.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         mode = (p < 5) ? mode_plan[p] : 2'($urandom_range(0, 3));
         write_tag_mode(mode);
         start = items_queued;
         while (items_queued - start < PHASE_ITEMS) begin
            sel = $urandom_range(0, 99);
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 14) : $urandom_range(0, 6);
            if (sel < 35) begin
               queue_packet(pite_pkg::CMD_GENERATE, mode, len, TAIL_GOOD);
            end else if (sel < 70) begin
               queue_packet(pite_pkg::CMD_VERIFY, mode, len, TAIL_GOOD);
            end else if (sel < 80) begin
               queue_packet(pite_pkg::CMD_VERIFY, mode, len, TAIL_FLIPPED);
            end else if (sel < 90) begin
               queue_packet(pite_pkg::CMD_VERIFY, mode, len + 1, TAIL_RAW);
            end else begin
               // Selector changes from byte to byte inside one packet.
               len = len + 1;
               for (int i = 0; i < len; i++)
                  in_bytes_q.push_back('{1'($urandom), 8'($urandom), (i == len - 1)});
               items_queued += len;
            end
         end
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

// ===== packet_integrity_tag_engine.f =====
hdl/pite_pkg.sv
hdl/pite_front.sv
hdl/pite_queue.sv
hdl/pite_back.sv
hdl/packet_integrity_tag_engine.sv
test/tb.sv
